@@ sv/qfpa_pkg.sv @@
// Shared types and constants for the quad and fan primitive assembler.
// Holds mode and opcode codes, the queue command format and the emit schedule.
// No dependencies.
`default_nettype none

package qfpa_pkg;

    localparam int HANDLE_W = 16;

    // Attribute store has 65536 slots, so a 16-bit handle never needs reducing.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] COUNT_MAX = 3'd7;

    localparam logic [1:0] MODE_PASS    = 2'd0;
    localparam logic [1:0] MODE_QUADS   = 2'd1;
    localparam logic [1:0] MODE_POLYGON = 2'd2;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_END    = 1'b1;

    localparam logic [1:0] SEL_H0 = 2'd0;
    localparam logic [1:0] SEL_H1 = 2'd1;
    localparam logic [1:0] SEL_H2 = 2'd2;
    localparam logic [1:0] SEL_H3 = 2'd3;

    // Longest command (a split quad) emits six results.
    localparam logic [2:0] STEP_MAX = 3'd5;

    typedef enum logic [2:0] {
        K_PASS,
        K_QUAD,
        K_FAN,
        K_END,
        K_END_TRI
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] h0;
        logic [HANDLE_W-1:0] h1;
        logic [HANDLE_W-1:0] h2;
        logic [HANDLE_W-1:0] h3;
    } t_cmd;

    typedef struct packed {
        logic [1:0] sel;
        logic       marker;
        logic       last;
    } t_step;

    // Which handle (or the end marker) goes out at a given step of a command.
    function automatic t_step step_info(t_kind kind, logic [2:0] step);
        t_step s;
        s = '0;
        case (kind)
            K_PASS: begin
                s.sel  = SEL_H3;
                s.last = 1'b1;
            end
            K_QUAD: begin
                case (step)
                    3'd0: s.sel = SEL_H0;
                    3'd1: s.sel = SEL_H1;
                    3'd2: s.sel = SEL_H2;
                    3'd3: s.sel = SEL_H0;
                    3'd4: s.sel = SEL_H2;
                    default: begin
                        s.sel  = SEL_H3;
                        s.last = 1'b1;
                    end
                endcase
            end
            K_FAN: begin
                case (step)
                    3'd0: s.sel = SEL_H0;
                    3'd1: s.sel = SEL_H1;
                    default: begin
                        s.sel  = SEL_H3;
                        s.last = 1'b1;
                    end
                endcase
            end
            K_END_TRI: begin
                case (step)
                    3'd0: s.sel = SEL_H0;
                    3'd1: s.sel = SEL_H1;
                    3'd2: s.sel = SEL_H2;
                    default: begin
                        s.marker = 1'b1;
                        s.last   = 1'b1;
                    end
                endcase
            end
            default: begin
                s.marker = 1'b1;
                s.last   = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ sv/qfpa_front.sv @@
// Front end: holds the mode register and batch state, classifies each accepted
// item and produces the command for the back end. Depends on qfpa_pkg.
`default_nettype none

module qfpa_front
    import qfpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [1:0]          i_prim_mode,
    input  wire logic                i_accept,
    input  wire logic                i_opcode,
    input  wire logic [HANDLE_W-1:0] i_vertex_handle,
    output      logic                o_push,
    output      t_cmd                o_cmd
);

    logic [1:0]          r_prim_mode;
    logic [1:0]          r_pos,   n_pos;
    logic [2:0]          r_count, n_count;
    logic [HANDLE_W-1:0] r_held [3];
    logic [HANDLE_W-1:0] n_held [3];
    logic                want_push;

    always_comb begin
        want_push = 1'b0;
        o_cmd.kind = K_END;
        o_cmd.h0 = r_held[0];
        o_cmd.h1 = r_held[1];
        o_cmd.h2 = r_held[2];
        o_cmd.h3 = i_vertex_handle;
        n_pos   = r_pos;
        n_count = r_count;
        n_held  = r_held;

        if (i_opcode == OP_END) begin
            want_push  = 1'b1;
            o_cmd.kind = (r_prim_mode == MODE_QUADS && r_count == 3'd3) ? K_END_TRI : K_END;
            n_pos   = 2'd0;
            n_count = 3'd0;
        end else begin
            case (r_prim_mode)
                MODE_QUADS: begin
                    if (r_pos == 2'd3) begin
                        want_push  = 1'b1;
                        o_cmd.kind = K_QUAD;
                        n_pos      = 2'd0;
                    end else begin
                        case (r_pos)
                            2'd0:    n_held[0] = i_vertex_handle;
                            2'd1:    n_held[1] = i_vertex_handle;
                            default: n_held[2] = i_vertex_handle;
                        endcase
                        n_pos = r_pos + 2'd1;
                    end
                end
                MODE_POLYGON: begin
                    if (r_count == 3'd0) begin
                        n_held[0] = i_vertex_handle;
                    end else begin
                        if (r_count >= 3'd2) begin
                            want_push  = 1'b1;
                            o_cmd.kind = K_FAN;
                        end
                        n_held[1] = i_vertex_handle;
                    end
                end
                default: begin
                    want_push  = 1'b1;
                    o_cmd.kind = K_PASS;
                end
            endcase
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 3'd1;
            end
        end
    end

    assign o_push = i_accept && want_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_mode <= MODE_PASS;
            r_pos       <= 2'd0;
            r_count     <= 3'd0;
        end else begin
            if (i_cfg_valid) begin
                r_prim_mode <= i_prim_mode;
            end
            if (i_accept) begin
                r_pos   <= n_pos;
                r_count <= n_count;
            end
        end
    end

    // Held vertices are undefined until written; no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

@@ sv/qfpa_cmd_queue.sv @@
// Short command queue between the front and back ends.
// Four entries of t_cmd, first in first out. Depends on qfpa_pkg.
`default_nettype none

module qfpa_cmd_queue
    import qfpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output      t_cmd o_head,
    output      logic o_full,
    output      logic o_empty
);

    t_cmd                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_head  = r_entry[r_rd];
    assign o_full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/qfpa_back.sv @@
// Back end: steps through the command at the head of the queue, one result per
// cycle while the receiver does not stall, into the output register. Depends on qfpa_pkg.
`default_nettype none

module qfpa_back
    import qfpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_head,
    input  wire logic                i_empty,
    output      logic                o_pop,
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      logic [HANDLE_W-1:0] o_out_handle,
    output      logic                o_handle_valid,
    output      logic                o_run_last,
    output      logic                o_batch_done
);

    logic [2:0]          r_step;
    logic                r_valid;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_hvalid;
    logic                r_last;
    logic                r_done;
    logic                advance;
    logic                issue;
    t_step               st;
    logic [HANDLE_W-1:0] sel_handle;

    assign advance = !r_valid || !i_stall;
    assign issue   = advance && !i_empty;
    assign st      = step_info(i_head.kind, r_step);
    assign o_pop   = issue && st.last;

    always_comb begin
        case (st.sel)
            SEL_H0:  sel_handle = i_head.h0;
            SEL_H1:  sel_handle = i_head.h1;
            SEL_H2:  sel_handle = i_head.h2;
            default: sel_handle = i_head.h3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= issue;
            if (issue) begin
                r_step <= st.last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_handle <= st.marker ? '0 : sel_handle;
            r_hvalid <= !st.marker;
            r_last   <= st.last;
            r_done   <= st.marker;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_handle   = r_handle;
    assign o_handle_valid = r_hvalid;
    assign o_run_last     = r_last;
    assign o_batch_done   = r_done;

    // A command in progress stays at the head of the queue.
    a_step_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 3'd0 |-> !i_empty)
        else $error("step counter running with empty queue");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_MAX)
        else $error("step counter beyond longest command");

    a_marker_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_done |-> r_last && !r_hvalid)
        else $error("end marker not last or carries a handle");

    a_pop_resets_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_step == 3'd0)
        else $error("step counter not cleared after pop");

endmodule

`default_nettype wire

@@ sv/quad_and_fan_primitive_assembler.sv @@
// Quad and fan primitive assembler: turns batches of vertex handles into a
// triangle list of handles. The back end emits one result per cycle while the
// receiver does not stall. An item yields one result for a pass-through vertex
// or an end marker, three per fanned polygon vertex, six per fourth quad vertex
// (a result and a half per vertex sustained), four for a three-vertex quad
// batch end. Items that emit nothing push no command. The front end accepts
// one item per cycle while its four-entry command queue has room; the output
// register lets a new result load in the same cycle the previous one is taken.
// Depends on qfpa_pkg, qfpa_front, qfpa_cmd_queue and qfpa_back.
`default_nettype none

module quad_and_fan_primitive_assembler
    import qfpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output      logic                o_cfg_ready,
    input  wire logic [1:0]          i_prim_mode,
    input  wire logic                i_valid,
    output      logic                o_stall,
    input  wire logic                i_opcode,
    input  wire logic [HANDLE_W-1:0] i_vertex_handle,
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      logic [HANDLE_W-1:0] o_out_handle,
    output      logic                o_handle_valid,
    output      logic                o_run_last,
    output      logic                o_batch_done
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd;
    t_cmd head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign accept      = i_valid && !full;

    qfpa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_prim_mode     (i_prim_mode),
        .i_accept        (accept),
        .i_opcode        (i_opcode),
        .i_vertex_handle (i_vertex_handle),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    qfpa_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    qfpa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_handle   (o_out_handle),
        .o_handle_valid (o_handle_valid),
        .o_run_last     (o_run_last),
        .o_batch_done   (o_batch_done)
    );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for quad_and_fan_primitive_assembler: directed batches,
// then random batches in all four modes with random gaps and receiver hold-offs.
// Depends on qfpa_pkg and the assembler RTL.
`timescale 1ns / 100ps

module tb
    import qfpa_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 50;
    localparam int ITEM_TARGET  = 210;

    typedef struct packed {
        logic                opcode;
        logic [HANDLE_W-1:0] handle;
    } t_vtx_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                hvalid;
        logic                run_last;
        logic                batch_done;
    } t_tri_entry;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_prim_mode = MODE_PASS;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_opcode = OP_VERTEX;
    logic [HANDLE_W-1:0] i_vertex_handle = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [HANDLE_W-1:0] o_out_handle;
    logic                o_handle_valid;
    logic                o_run_last;
    logic                o_batch_done;

    quad_and_fan_primitive_assembler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_prim_mode     (i_prim_mode),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_vertex_handle (i_vertex_handle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_handle    (o_out_handle),
        .o_handle_valid  (o_handle_valid),
        .o_run_last      (o_run_last),
        .o_batch_done    (o_batch_done)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_vtx_item  vertex_stream[$];
    t_tri_entry predicted_list[$];

    // Mirror of the assembler state
    logic [1:0]          mode_copy = MODE_PASS;
    logic [HANDLE_W-1:0] held [3] = '{default: '0};
    logic [1:0]          grp_pos = '0;
    logic [2:0]          vtx_count = '0;

    bit item_taken = 1'b0;
    bit steady = 1'b0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    int queued_items = 0;
    int items_taken = 0;
    int batches_closed = 0;
    int results_checked = 0;
    int mode_writes = 0;
    int mismatches = 0;

    function automatic void emit_entry(logic [HANDLE_W-1:0] h, logic hv, logic done);
        t_tri_entry e;
        e = '{h, hv, 1'b0, done};
        predicted_list.insert(predicted_list.size(), e);
    endfunction

    function automatic void assemble_prims(logic op, logic [HANDLE_W-1:0] h);
        int first;
        first = predicted_list.size();
        if (op == OP_END) begin
            // three-vertex quad batch flushes as one triangle
            if (mode_copy == MODE_QUADS && vtx_count == 3'd3) begin
                emit_entry(held[0], 1'b1, 1'b0);
                emit_entry(held[1], 1'b1, 1'b0);
                emit_entry(held[2], 1'b1, 1'b0);
            end
            emit_entry('0, 1'b0, 1'b1);
            grp_pos   = '0;
            vtx_count = '0;
        end else begin
            case (mode_copy)
                MODE_QUADS: begin
                    if (grp_pos == 2'd3) begin
                        emit_entry(held[0], 1'b1, 1'b0);
                        emit_entry(held[1], 1'b1, 1'b0);
                        emit_entry(held[2], 1'b1, 1'b0);
                        emit_entry(held[0], 1'b1, 1'b0);
                        emit_entry(held[2], 1'b1, 1'b0);
                        emit_entry(h, 1'b1, 1'b0);
                        grp_pos = '0;
                    end else begin
                        held[grp_pos] = h;
                        grp_pos = grp_pos + 2'd1;
                    end
                end
                MODE_POLYGON: begin
                    if (vtx_count == 3'd0) begin
                        held[0] = h;
                    end else begin
                        if (vtx_count >= 3'd2) begin
                            emit_entry(held[0], 1'b1, 1'b0);
                            emit_entry(held[1], 1'b1, 1'b0);
                            emit_entry(h, 1'b1, 1'b0);
                        end
                        held[1] = h;
                    end
                end
                default: begin
                    emit_entry(h, 1'b1, 1'b0);
                end
            endcase
            if (vtx_count < COUNT_MAX)
                vtx_count = vtx_count + 3'd1;
        end
        if (predicted_list.size() > first)
            predicted_list[predicted_list.size() - 1].run_last = 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [HANDLE_W-1:0] want,
                               input logic [HANDLE_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Input side: record each accepted transaction and predict its results
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            assemble_prims(i_opcode, i_vertex_handle);
            item_taken = 1'b1;
            items_taken++;
            if (i_opcode == OP_END)
                batches_closed++;
        end
    end

    // Driver: advance to the next pending item once the current one is taken
    always @(negedge i_clk) begin
        t_vtx_item nxt;
        if (!i_valid || item_taken) begin
            item_taken = 1'b0;
            if (vertex_stream.size() > 0 && (steady || $urandom_range(0, 99) >= 12)) begin
                nxt = vertex_stream.pop_front();
                i_valid         <= 1'b1;
                i_opcode        <= nxt.opcode;
                i_vertex_handle <= nxt.handle;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !steady && ($urandom_range(0, 99) < 12);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_tri_entry want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_list.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, %s %h valid %b last %b done %b",
                         $time, "actual handle", o_out_handle, o_handle_valid,
                         o_run_last, o_batch_done);
            end else begin
                want = predicted_list.pop_front();
                check_field("out_handle", want.handle, o_out_handle);
                check_field("handle_valid", 16'(want.hvalid), 16'(o_handle_valid));
                check_field("run_last", 16'(want.run_last), 16'(o_run_last));
                check_field("batch_done", 16'(want.batch_done), 16'(o_batch_done));
            end
            results_checked++;
        end
    end

    task automatic push_vtx(input logic [HANDLE_W-1:0] h);
        t_vtx_item it;
        it = '{OP_VERTEX, h};
        vertex_stream.insert(vertex_stream.size(), it);
        queued_items++;
    endtask

    task automatic push_end();
        t_vtx_item it;
        // handle is ignored on an end transaction, drive noise on it
        it = '{OP_END, HANDLE_W'($urandom_range(0, 65535))};
        vertex_stream.insert(vertex_stream.size(), it);
        queued_items++;
    endtask

    task automatic queue_batch(input int n, input bit close);
        for (int k = 0; k < n; k++)
            push_vtx(HANDLE_W'($urandom_range(0, 65535)));
        if (close)
            push_end();
    endtask

    task automatic wait_drained();
        while (vertex_stream.size() != 0 || i_valid || predicted_list.size() != 0)
            @(posedge i_clk);
        // let items that emit nothing clear the pipeline
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_prim_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        mode_copy = m;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int batch_size(logic [1:0] m);
        int r;
        r = $urandom_range(0, 9);
        case (m)
            MODE_QUADS: begin
                if (r < 5)
                    return 4 * $urandom_range(1, 2);
                else if (r < 7)
                    return 3;
                return $urandom_range(0, 9);
            end
            MODE_POLYGON: begin
                if (r < 7)
                    return $urandom_range(3, 9);
                return $urandom_range(0, 2);
            end
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    initial begin
        logic [1:0] m;
        int phase;
        int n_batches;
        int r;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unused mode acts as pass-through
        set_mode(MODE_UNUSED);
        push_vtx(16'h0000);
        push_vtx(16'hFFFF);
        push_end();

        // Quads: empty batch, one quad plus a leftover, then a lone triangle
        set_mode(MODE_QUADS);
        push_end();
        push_vtx(16'hAAAA);
        push_vtx(16'h5555);
        push_vtx(16'h0001);
        push_vtx(16'h8000);
        push_vtx(16'h7FFF);
        push_end();
        push_vtx(16'hFFFE);
        push_vtx(16'h0000);
        push_vtx(16'h1234);
        push_end();

        // Polygon: single-vertex batch, then a four-vertex fan
        set_mode(MODE_POLYGON);
        push_vtx(16'hFFFF);
        push_end();
        push_vtx(16'h0F0F);
        push_vtx(16'hF0F0);
        push_vtx(16'h00FF);
        push_vtx(16'hFF00);
        push_end();

        // Mode change mid-batch: counters and held vertices carry over
        push_vtx(16'hC3C3);
        push_vtx(16'h3C3C);
        set_mode(MODE_QUADS);
        push_vtx(16'h9999);
        push_end();

        phase = 0;
        while (queued_items < ITEM_TARGET) begin
            if (phase == 0)
                m = MODE_PASS;
            else if (phase == 1)
                m = MODE_POLYGON;
            else if (phase == 2)
                m = MODE_QUADS;
            else begin
                r = $urandom_range(0, 9);
                m = (r < 3) ? MODE_PASS : (r < 6) ? MODE_QUADS :
                    (r < 9) ? MODE_POLYGON : MODE_UNUSED;
            end
            set_mode(m);
            steady = (phase == 3);
            n_batches = $urandom_range(2, 5);
            for (int b = 0; b < n_batches; b++)
                // now and then leave the last batch open across the mode change
                queue_batch(batch_size(m), !(b == n_batches - 1 && $urandom_range(0, 4) == 0));
            if (phase == 1 || phase == 6)
                hold_asks++;
            phase++;
        end
        push_end();
        wait_drained();
        steady = 1'b0;

        $display("Run covered %0d transactions in %0d batches across %0d mode writes,",
                 items_taken, batches_closed, mode_writes);
        $display("%s %0d results checked.",
                 "all four modes, mid-batch mode changes and long output hold-offs;",
                 results_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
